// File: rtl/core/lcgf_pkg.sv
// Shared types and constants for the LCG byte and letter fill block.
// Used by the front end, the request queue and the back end; depends on nothing.
`default_nettype none

package lcgf_pkg;

  // Generator: x' = x * LcgMul + LcgAdd (mod 2^64)
  localparam int unsigned MulWidth = 21;
  localparam logic [MulWidth-1:0] LcgMul = 21'd1664525;
  localparam logic [63:0]         LcgAdd = 64'd1013904223;

  // Output alphabet
  localparam logic [7:0] LetterBase  = 8'd97;  // ASCII 'a'
  localparam logic [4:0] LetterCount = 5'd26;

  // Beats produced by one generator step in chunked operation
  localparam int unsigned ByteChunk   = 8;
  localparam int unsigned LetterChunk = 12;
  // Byte mode uses chunks from this length up; letter mode only above LetterChunk - 1
  localparam logic [6:0] ByteChunkMinLen = 7'd10;

  // Reduction mod 13: 2^12 = 1 (mod 13), and floor(2^16 / 13) as a reciprocal
  localparam logic [12:0] Recip13 = 13'd5041;
  localparam logic [3:0]  Thirteen = 4'd13;

  // Request queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // One classified fill request
  typedef struct packed {
    logic        mode;     // 0 bytes, 1 letters
    logic [3:0]  chunks;   // number of multi-beat steps
    logic [3:0]  singles;  // number of one-beat steps after the chunks
    logic [63:0] seed;
  } req_t;

  localparam logic ModeBytes   = 1'b0;
  localparam logic ModeLetters = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_SUM,
    S_REDUCE,
    S_ONE,
    S_CHUNK
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/lcgf_front.sv
// Front end: takes fill requests, saturates the length and splits it into chunks and singles.
// Depends on lcgf_pkg; feeds lcgf_fifo.
`default_nettype none

module lcgf_front #(
  parameter int MAX_FILL = 64
) (
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [71:0]         s_tdata,   // fill_length[6:0], start_value[70:7], zero pad
  input  wire                 s_tuser,   // command
  input  wire                 q_full,
  output logic                push,
  output lcgf_pkg::req_t      push_req
);
  import lcgf_pkg::*;

  localparam logic [6:0] MaxLen = 7'(MAX_FILL);
  localparam int MaxLetterChunks = MAX_FILL / LetterChunk;

  logic [6:0] len;
  logic [3:0] letter_chunks;
  logic [6:0] letter_used;

  // Saturate the requested length
  assign len = (s_tdata[6:0] > MaxLen) ? MaxLen : s_tdata[6:0];

  // Whole 12-letter chunks that fit into the length
  always_comb begin
    letter_chunks = '0;
    for (int k = 1; k <= MaxLetterChunks; k++) begin
      letter_chunks = letter_chunks + 4'(len >= 7'(LetterChunk * k));
    end
  end

  assign letter_used = 7'(letter_chunks) * 7'(LetterChunk);

  // Classify the request
  always_comb begin
    push_req.mode = s_tuser;
    push_req.seed = s_tdata[70:7];
    if (s_tuser == ModeLetters) begin
      push_req.chunks  = letter_chunks;
      push_req.singles = 4'(len - letter_used);
    end else if (len >= ByteChunkMinLen) begin
      push_req.chunks  = 4'(len >> 3);
      push_req.singles = {1'b0, len[2:0]};
    end else begin
      push_req.chunks  = '0;
      push_req.singles = 4'(len);
    end
  end

  // A zero-length request is taken and produces nothing
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full && (len != 7'd0);

endmodule

`default_nettype wire

// File: rtl/core/lcgf_fifo.sv
// Short request queue that decouples the front end from the back end.
// Depends on lcgf_pkg for the request type and depth.
`default_nettype none

module lcgf_fifo (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  lcgf_pkg::req_t      push_req,
  output logic                full,
  input  wire                 pop,
  output logic                pop_valid,
  output lcgf_pkg::req_t      pop_req
);
  import lcgf_pkg::*;

  req_t                 slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == (QueuePtrW+1)'(QueueDepth));
  assign pop_valid = (count != '0);
  assign pop_req   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_req;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

// File: rtl/core/lcgf_back.sv
// Back end: steps the 64-bit generator and emits one byte or letter per beat.
// Depends on lcgf_pkg; takes requests from lcgf_fifo.
`default_nettype none

module lcgf_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  input  lcgf_pkg::req_t      q_req,
  output logic                pop,
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [71:0]         m_tdata,   // out_byte[7:0], end_value[71:8]
  output logic                m_tlast    // last
);
  import lcgf_pkg::*;

  back_state_t state, state_next;

  logic [63:0] x;
  logic [52:0] prod_lo;
  logic [31:0] prod_hi;
  logic [52:0] hi_full;
  logic [3:0]  chunks_left;
  logic [3:0]  singles_left;
  logic        mode;
  logic [3:0]  pos;
  logic [14:0] msum;
  logic [7:0]  letter;

  logic [7:0]  out_byte;
  logic        out_last;
  logic [63:0] out_end;

  logic        out_free;
  logic        emit;
  logic        emit_last;
  logic [7:0]  emit_byte;
  logic        chunk_end;

  logic [7:0]  byte_lane [ByteChunk];
  logic [7:0]  letter_lane [LetterChunk];
  logic [62:0] y;
  logic [12:0] fold1;
  logic [11:0] fold2;
  logic [24:0] recip_prod;
  logic [11:0] quot;
  logic [11:0] rem_wide;
  logic [3:0]  rem13;

  assign out_free = !m_tvalid || m_tready;

  // Lanes of the current generator value for chunked beats
  always_comb begin
    for (int k = 0; k < ByteChunk; k++) begin
      byte_lane[k] = x[8*k +: 8];
    end
    for (int k = 0; k < LetterChunk; k++) begin
      letter_lane[k] = LetterBase +
        ((x[5*k +: 5] >= LetterCount) ? 8'(x[5*k +: 5] - LetterCount) : 8'(x[5*k +: 5]));
    end
  end

  // Whole value mod 26 as 2 * ((x >> 1) mod 13) + x[0]
  assign y        = x[63:1];
  assign fold1    = 13'(msum[11:0]) + 13'(msum[14:12]);
  assign fold2    = fold1[11:0] + 12'(fold1[12]);
  assign recip_prod = 25'(fold2) * 25'(Recip13);
  assign quot     = 12'(recip_prod[24:16]);
  assign rem_wide = fold2 - quot * 12'(Thirteen);
  assign rem13    = (rem_wide >= 12'(Thirteen)) ? 4'(rem_wide - 12'(Thirteen)) : 4'(rem_wide);

  // Upper partial product, kept to the bits that land below 2^64
  assign hi_full = x[63:32] * LcgMul;

  assign chunk_end = (mode == ModeLetters) ? (pos == 4'(LetterChunk - 1))
                                           : (pos == 4'(ByteChunk - 1));

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and beat control
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_byte  = (mode == ModeLetters) ? letter_lane[pos] : byte_lane[pos[2:0]];
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_ADD;
      S_ADD: begin
        if (chunks_left != '0)          state_next = S_CHUNK;
        else if (mode == ModeLetters)   state_next = S_SUM;
        else                            state_next = S_ONE;
      end
      S_SUM:    state_next = S_REDUCE;
      S_REDUCE: state_next = S_ONE;
      S_ONE: begin
        emit_byte = (mode == ModeLetters) ? letter : x[7:0];
        emit_last = (singles_left == '0);
        if (out_free) begin
          emit       = 1'b1;
          state_next = emit_last ? S_IDLE : S_MUL;
        end
      end
      S_CHUNK: begin
        emit_last = chunk_end && (chunks_left == '0) && (singles_left == '0);
        if (out_free) begin
          emit = 1'b1;
          if (chunk_end) state_next = emit_last ? S_IDLE : S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Request counters, mode and chunk position
  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_left  <= '0;
      singles_left <= '0;
      mode         <= ModeBytes;
      pos          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            chunks_left  <= q_req.chunks;
            singles_left <= q_req.singles;
            mode         <= q_req.mode;
          end
        end
        S_ADD: begin
          pos <= '0;
          if (chunks_left != '0) chunks_left  <= chunks_left - 1'b1;
          else                   singles_left <= singles_left - 1'b1;
        end
        S_CHUNK: begin
          if (emit) pos <= pos + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) x <= q_req.seed;
    if (state == S_MUL) begin
      prod_lo <= x[31:0] * LcgMul;
      prod_hi <= hi_full[31:0];
    end
    if (state == S_ADD) x <= 64'(prod_lo) + {prod_hi, 32'h0} + LcgAdd;
    if (state == S_SUM) begin
      msum <= 15'(y[11:0]) + 15'(y[23:12]) + 15'(y[35:24]) +
              15'(y[47:36]) + 15'(y[59:48]) + 15'(y[62:60]);
    end
    if (state == S_REDUCE) letter <= LetterBase + 8'({rem13, x[0]});
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
      out_end  <= emit_last ? x : 64'h0;
    end
  end

  assign m_tdata = {out_end, out_byte};
  assign m_tlast = out_last;

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> out_end == 64'h0)
    else $error("end value set on a beat that is not the last");

  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ONE && mode == ModeLetters |-> letter >= LetterBase &&
      letter < LetterBase + 8'(LetterCount))
    else $error("single letter out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("beat overwrote a pending output");

  a_chunk_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_CHUNK |-> pos < 4'(LetterChunk))
    else $error("chunk position out of range");

endmodule

`default_nettype wire

// File: rtl/core/lcg_byte_and_letter_fill.sv
// Top level of the LCG byte and letter fill block.
// Depends on lcgf_pkg, lcgf_front, lcgf_fifo and lcgf_back.
//
//   channel  | dir | tdata                                   | tuser   | tlast
//   s_ (req) | in  | fill_length[6:0], start_value[70:7]     | command | -
//   m_ (out) | out | out_byte[7:0], end_value[71:8]          | -       | last
//
// A request leaves the queue in S_IDLE, then each generator step runs the split 64x21
// multiply-add in S_MUL and S_ADD, followed by 8 or 12 beats for a chunk, one beat for a
// single byte, or the reduction states S_SUM and S_REDUCE and one beat for a single letter.
// The sequencer in lcgf_back sets the rate; the queue holds two requests.
// Reset is synchronous; zero-length requests are taken and produce no beats.
// A stalled output holds its beat while the front keeps taking requests until the queue is full.
`default_nettype none

module lcg_byte_and_letter_fill #(
  parameter int MAX_FILL = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [71:0] s_tdata,   // fill_length[6:0], start_value[70:7], zero pad [71]
  input  wire         s_tuser,   // command
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,   // out_byte[7:0], end_value[71:8]
  output logic        m_tlast
);
  import lcgf_pkg::*;

  logic q_full;
  logic push;
  req_t push_req;
  logic pop;
  logic q_valid;
  req_t q_req;

  // Request intake and classification
  lcgf_front #(
    .MAX_FILL (MAX_FILL)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_req (push_req)
  );

  // Queue between front and back
  lcgf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_req  (push_req),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_req   (q_req)
  );

  // Generator and beat emission
  lcgf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
